### hdl/wsps_pkg.sv
// Shared types and constants for the windowed site peak suppression block.
package wsps_pkg;
  localparam int unsigned DefBufferDepth = 64;
  localparam int unsigned PosW = 32;
  localparam int unsigned ScoreW = 32;
  localparam int unsigned WinW = 10;

  localparam logic [9:0] RstAccWindow = 10'd100;
  localparam logic [9:0] RstDonWindow = 10'd150;
  localparam logic [31:0] RstAccLimit = 32'd928139;
  localparam logic [31:0] RstDonLimit = 32'd866424;

  typedef enum logic [1:0] {
    RegAccWindow = 2'd0,
    RegDonWindow = 2'd1,
    RegAccLimit  = 2'd2,
    RegDonLimit  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [9:0]  acc_window;
    logic [9:0]  don_window;
    logic [31:0] acc_limit;
    logic [31:0] don_limit;
  } cfg_t;

  typedef struct packed {
    logic        has_site;
    logic        site_kind;
    logic [31:0] site_position;
    logic [31:0] site_score;
    logic        end_of_sequence;
  } in_word_t;

  typedef struct packed {
    logic [31:0] kept_position;
    logic        kept_kind;
    logic [31:0] kept_score;
    logic        high_confidence;
    logic        buffer_overflowed;
    logic        last_of_run;
  } out_word_t;
endpackage

### hdl/wsps_if.sv
// Valid/ready channel interface carrying one word.
interface wsps_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/wsps_cfg.sv
// APB-style configuration register file.
module wsps_cfg import wsps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);
  cfg_t cfg_q;
  reg_idx_e idx;
  assign idx = reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{RstAccWindow, RstDonWindow, RstAccLimit, RstDonLimit};
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        RegAccWindow: cfg_q.acc_window <= pwdata[9:0];
        RegDonWindow: cfg_q.don_window <= pwdata[9:0];
        RegAccLimit:  cfg_q.acc_limit <= pwdata;
        RegDonLimit:  cfg_q.don_limit <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegAccWindow: prdata = {22'd0, cfg_q.acc_window};
      RegDonWindow: prdata = {22'd0, cfg_q.don_window};
      RegAccLimit:  prdata = cfg_q.acc_limit;
      RegDonLimit:  prdata = cfg_q.don_limit;
      default:      prdata = '0;
    endcase
  end
endmodule

### hdl/wsps_core.sv
// Sequencer walking the site buffer with one shared compare unit.
module wsps_core import wsps_pkg::*; #(
  parameter int unsigned BufferDepth = DefBufferDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  wsps_if.sink   in_if,
  wsps_if.source out_if
);
  localparam int unsigned AW = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
  localparam int unsigned FW = $clog2(BufferDepth + 1);
  localparam logic [FW-1:0] DepthF = FW'(BufferDepth);

  typedef enum logic [6:0] {
    SIdle  = 7'b0000001,
    SScanR = 7'b0000010,
    SScan  = 7'b0000100,
    SHeadR = 7'b0001000,
    SHead  = 7'b0010000,
    SPop   = 7'b0100000,
    SEmit  = 7'b1000000
  } state_e;

  // pop reasons
  typedef enum logic [2:0] {
    PopWin = 3'b001,
    PopOvf = 3'b010,
    PopEos = 3'b100
  } pop_e;

  state_e state_q, state_d;
  pop_e pop_q, pop_d;
  in_word_t in_q;
  logic [31:0] pos_mem [BufferDepth];
  logic [31:0] sc_mem [BufferDepth];
  logic [BufferDepth-1:0] kind_q, later_q, early_q;
  logic [AW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d, cnt_q, cnt_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic [31:0] rd_pos_q, rd_sc_q;
  logic nf_early_q, nf_early_d;
  logic pend_q, pend_d;
  out_word_t pend_w_q, pend_w_d, out_q;
  logic out_v_q;
  logic wr_en, set_later, clr_flags;
  logic [AW-1:0] wr_addr, scan_addr;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] a);
    wrap = (a >= (AW+1)'(BufferDepth)) ? AW'(a - (AW+1)'(BufferDepth)) : a[AW-1:0];
  endfunction

  logic [AW-1:0] rd_idx;
  logic in_win, kind_m, head_out;
  logic [31:0] pos_gap;
  logic [9:0] win;
  logic lt, gt;
  assign rd_idx = rd_addr_q;
  assign pos_gap = in_q.site_position - rd_pos_q;
  assign win = kind_q[rd_idx] ? cfg_i.don_window : cfg_i.acc_window;
  assign in_win = pos_gap <= {22'd0, win};
  assign kind_m = kind_q[rd_idx] == in_q.site_kind;
  assign lt = $signed(rd_sc_q) < $signed(in_q.site_score);
  assign gt = $signed(rd_sc_q) > $signed(in_q.site_score);
  assign head_out = !in_win;

  assign scan_addr = wrap({1'b0, head_q} + {1'b0, cnt_q[AW-1:0]});
  assign wr_addr = wrap({1'b0, head_q} + {1'b0, fill_q[AW-1:0]});

  assign in_if.ready = (state_q == SIdle) && !pend_q;
  assign out_if.valid = out_v_q;
  assign out_if.data = out_q;

  logic out_free;
  assign out_free = !out_v_q || out_if.ready;

  // read data is registered from the next address, so it lands in the cycle after that address is chosen
  always_ff @(posedge clk_i) begin
    rd_pos_q <= pos_mem[rd_addr_d];
    rd_sc_q <= sc_mem[rd_addr_d];
    if (wr_en) begin
      pos_mem[wr_addr] <= in_q.site_position;
      sc_mem[wr_addr] <= in_q.site_score;
    end
    if (in_if.valid && in_if.ready) in_q <= in_if.data;
    pend_w_q <= pend_w_d;
  end

  logic push_pend;
  out_word_t pop_word;
  logic pop_keep;
  assign pop_keep = !later_q[head_q] && !early_q[head_q];
  always_comb begin
    pop_word.kept_position = rd_pos_q;
    pop_word.kept_kind = kind_q[head_q];
    pop_word.kept_score = rd_sc_q;
    pop_word.high_confidence = $signed(rd_sc_q) >= $signed(kind_q[head_q] ?
                               cfg_i.don_limit : cfg_i.acc_limit);
    pop_word.buffer_overflowed = (pop_q == PopOvf);
    pop_word.last_of_run = 1'b0;
  end

  always_comb begin
    state_d = state_q; pop_d = pop_q; head_d = head_q; fill_d = fill_q;
    cnt_d = cnt_q; nf_early_d = nf_early_q; pend_d = pend_q; pend_w_d = pend_w_q;
    rd_addr_d = rd_addr_q; wr_en = 1'b0; set_later = 1'b0; clr_flags = 1'b0;
    push_pend = 1'b0;
    // one-word hold: pending result moves out when a newer one or the end shows up
    unique case (state_q)
      SIdle: begin
        if (in_if.valid && in_if.ready) begin
          cnt_d = '0; nf_early_d = 1'b0; rd_addr_d = head_q;
          // a word with neither site nor end touches nothing
          if (in_if.data.has_site) state_d = SScanR;
          else if (in_if.data.end_of_sequence) state_d = SHeadR;
          else state_d = SEmit;
          pop_d = in_if.data.has_site ? PopWin : PopEos;
        end
      end
      SScanR: begin
        if (cnt_q >= fill_q) begin
          rd_addr_d = head_q; state_d = SHeadR;
        end else begin
          rd_addr_d = scan_addr; state_d = SScan;
        end
      end
      SScan: begin
        if (kind_m && in_win) begin
          if (lt) set_later = 1'b1;
          else if (gt && !later_q[rd_idx]) nf_early_d = 1'b1;
        end
        cnt_d = cnt_q + 1'b1; state_d = SScanR;
      end
      SHeadR: begin
        rd_addr_d = head_q;
        if (fill_q == '0) begin
          if (pop_q == PopWin) begin
            wr_en = 1'b1; fill_d = fill_q + 1'b1;
            pop_d = in_q.end_of_sequence ? PopEos : PopOvf;
            if (!in_q.end_of_sequence && (fill_q + 1'b1 >= DepthF)) state_d = SHead;
            else if (in_q.end_of_sequence) state_d = SHeadR;
            else state_d = SEmit;
          end else begin
            head_d = '0; state_d = SEmit;
          end
        end else state_d = SHead;
      end
      SHead: begin
        if (pop_q == PopWin && !head_out) begin
          wr_en = 1'b1; fill_d = fill_q + 1'b1; rd_addr_d = head_q;
          if (in_q.end_of_sequence) begin pop_d = PopEos; state_d = SHeadR; end
          else if (fill_q + 1'b1 >= DepthF) begin pop_d = PopOvf; state_d = SHead; end
          else state_d = SEmit;
        end else state_d = SPop;
      end
      SPop: begin
        if (!pend_q || out_free) begin
          if (pop_keep) push_pend = 1'b1;
          clr_flags = 1'b1;
          head_d = wrap({1'b0, head_q} + 1'b1);
          fill_d = fill_q - 1'b1;
          rd_addr_d = head_d;
          if (pop_q == PopOvf) state_d = SEmit;
          else state_d = SHeadR;
        end
      end
      SEmit: begin
        if (!pend_q) state_d = SIdle;
        else if (out_free) begin pend_d = 1'b0; state_d = SIdle; end
      end
      default: state_d = SIdle;
    endcase
    if (push_pend) begin pend_d = 1'b1; pend_w_d = pop_word; end
  end

  logic out_send;
  out_word_t out_word;
  assign out_send = pend_q && out_free && (push_pend || (state_q == SEmit));
  always_comb begin
    out_word = pend_w_q;
    out_word.last_of_run = (state_q == SEmit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; pop_q <= PopWin; head_q <= '0; fill_q <= '0; cnt_q <= '0;
      nf_early_q <= 1'b0; pend_q <= 1'b0; out_v_q <= 1'b0; rd_addr_q <= '0;
      kind_q <= '0; later_q <= '0; early_q <= '0; out_q <= '0;
    end else begin
      state_q <= state_d; pop_q <= pop_d; head_q <= head_d; fill_q <= fill_d;
      cnt_q <= cnt_d; nf_early_q <= nf_early_d; pend_q <= pend_d;
      rd_addr_q <= rd_addr_d;
      if (set_later) later_q[rd_idx] <= 1'b1;
      if (clr_flags) begin
        later_q[head_q] <= 1'b0; early_q[head_q] <= 1'b0; kind_q[head_q] <= 1'b0;
      end
      if (wr_en) begin
        kind_q[wr_addr] <= in_q.site_kind;
        later_q[wr_addr] <= 1'b0;
        early_q[wr_addr] <= nf_early_q;
      end
      // a pending word is released when another arrives or the item ends
      if (out_free) out_v_q <= out_send;
      if (out_send) out_q <= out_word;
    end
  end
endmodule

### hdl/windowed_site_peak_suppression.sv
// Top level: windowed site peak suppression with APB configuration.
// Each site word walks the buffer once with a single compare unit for the window
// scan, then retires old sites from the head of the buffer one by one; ready is
// low until the item is done, also through any output stalls. Results leave one
// per cycle at most, held one word back so the last of a run is marked.
module windowed_site_peak_suppression import wsps_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = DefBufferDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  wsps_if.sink         in_if,
  wsps_if.source       out_if
);
  cfg_t cfg;
  wsps_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );
  wsps_core #(.BufferDepth(BUFFER_DEPTH)) u_core (
    .clk_i, .rst_ni, .cfg_i(cfg), .in_if(in_if), .out_if(out_if)
  );
endmodule

### bench/wsps_checker.sv
// Checker: tracks the site buffer, predicts kept sites and compares them with the output.
module wsps_checker import wsps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_word_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_word_t   out_data_i,
  output int          fails_o,
  output int          pending_o
);
  localparam int unsigned Depth = DefBufferDepth;
  localparam logic [2:0] FlagLater = 3'b010;
  localparam logic [2:0] FlagEarlier = 3'b100;

  cfg_t        cfg;
  logic [31:0] site_pos [Depth];
  logic [31:0] site_score [Depth];
  logic [2:0]  site_flags [Depth];
  int unsigned head;
  int unsigned fill;
  int          step_count;
  out_word_t   kept_q [$];

  assign pending_o = kept_q.size();

  function automatic logic [9:0] window_for(logic kind);
    return kind ? cfg.don_window : cfg.acc_window;
  endfunction

  task automatic retire_oldest(input logic ovf);
    out_word_t   w;
    logic [2:0]  fl;
    logic [31:0] lim;
    fl = site_flags[head];
    if ((fl & (FlagLater | FlagEarlier)) == 3'b000) begin
      lim = fl[0] ? cfg.don_limit : cfg.acc_limit;
      w.kept_position = site_pos[head];
      w.kept_kind = fl[0];
      w.kept_score = site_score[head];
      w.high_confidence = $signed(site_score[head]) >= $signed(lim);
      w.buffer_overflowed = ovf;
      w.last_of_run = 1'b0;
      kept_q = {kept_q, w};
      step_count++;
    end
    site_flags[head] = 3'b000;
    head = (head + 1) % Depth;
    fill--;
  endtask

  task automatic predict_site_word(input in_word_t w);
    int unsigned idx;
    logic [2:0]  nf;
    logic [2:0]  fl;
    step_count = 0;
    if (w.has_site) begin
      nf = {2'b00, w.site_kind};
      for (int unsigned i = 0; i < fill; i++) begin
        idx = (head + i) % Depth;
        fl = site_flags[idx];
        if (fl[0] == w.site_kind &&
            (w.site_position - site_pos[idx]) <= {22'd0, window_for(w.site_kind)}) begin
          if ($signed(site_score[idx]) < $signed(w.site_score))
            site_flags[idx] = fl | FlagLater;
          else if ($signed(site_score[idx]) > $signed(w.site_score) && !fl[1])
            nf = nf | FlagEarlier;
        end
      end
      while (fill > 0 && (w.site_position - site_pos[head]) >
             {22'd0, window_for(site_flags[head][0])})
        retire_oldest(1'b0);
      idx = (head + fill) % Depth;
      site_pos[idx] = w.site_position;
      site_score[idx] = w.site_score;
      site_flags[idx] = nf;
      fill++;
      if (!w.end_of_sequence && fill >= Depth) retire_oldest(1'b1);
    end
    if (w.end_of_sequence) begin
      while (fill > 0) retire_oldest(1'b0);
      head = 0;
    end
    if (step_count > 0) kept_q[$].last_of_run = 1'b1;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %h expected %h", what, got, want);
    fails_o++;
  endtask

  initial begin
    fails_o = 0;
    cfg = '{RstAccWindow, RstDonWindow, RstAccLimit, RstDonLimit};
    head = 0;
    fill = 0;
    for (int i = 0; i < Depth; i++) site_flags[i] = 3'b000;
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (kept_q.size() == 0) begin
          report_mismatch("unexpected word at position", out_data_i.kept_position, '0);
        end else begin
          want = kept_q.pop_front();
          if (out_data_i.kept_position !== want.kept_position)
            report_mismatch("kept_position", out_data_i.kept_position, want.kept_position);
          if (out_data_i.kept_kind !== want.kept_kind)
            report_mismatch("kept_kind", out_data_i.kept_kind, want.kept_kind);
          if (out_data_i.kept_score !== want.kept_score)
            report_mismatch("kept_score", out_data_i.kept_score, want.kept_score);
          if (out_data_i.high_confidence !== want.high_confidence)
            report_mismatch("high_confidence", out_data_i.high_confidence,
                            want.high_confidence);
          if (out_data_i.buffer_overflowed !== want.buffer_overflowed)
            report_mismatch("buffer_overflowed", out_data_i.buffer_overflowed,
                            want.buffer_overflowed);
          if (out_data_i.last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", out_data_i.last_of_run, want.last_of_run);
        end
      end
      if (in_valid_i && in_ready_i) predict_site_word(in_data_i);
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[3:2]))
          RegAccWindow: cfg.acc_window = pwdata[9:0];
          RegDonWindow: cfg.don_window = pwdata[9:0];
          RegAccLimit:  cfg.acc_limit = pwdata;
          RegDonLimit:  cfg.don_limit = pwdata;
          default: ;
        endcase
      end
    end
  end
endmodule

### bench/windowed_site_peak_suppression_tb.sv
// Testbench top: stimulus, register setup and verdict for windowed site peak suppression.
module windowed_site_peak_suppression_tb;
  import wsps_pkg::*;

  localparam int DrainCycles = 400;
  localparam int CycleLimit = 1500000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fails;
  int          pending;
  int          cycles = 0;
  bit          no_idle = 1'b0;
  logic [31:0] cursor;
  bit          dense;

  wsps_if #(.word_t(in_word_t))  in_ch ();
  wsps_if #(.word_t(out_word_t)) out_ch ();

  windowed_site_peak_suppression u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  wsps_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready), .in_data_i(in_ch.data),
    .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready), .out_data_i(out_ch.data),
    .fails_o(fails), .pending_o(pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk_i)
    out_ch.ready <= no_idle || ($urandom_range(99) >= 35);

  task automatic send_word(input in_word_t w);
    if (!no_idle && $urandom_range(99) < 35) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.data = w;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic send_site(input logic kind, input logic [31:0] pos,
                           input logic [31:0] score, input logic eos);
    send_word('{1'b1, kind, pos, score, eos});
  endtask

  // the block may still be scanning after a word that keeps nothing
  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [31:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic load_config(input logic [9:0] aw, input logic [9:0] dw,
                             input logic [31:0] al, input logic [31:0] dl);
    settle();
    reg_write(RegAccWindow, {22'd0, aw});
    reg_write(RegDonWindow, {22'd0, dw});
    reg_write(RegAccLimit, al);
    reg_write(RegDonLimit, dl);
  endtask

  function automatic logic [31:0] pick_score();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return $urandom;
      default: return 32'(int'($urandom_range(0, 40)) - 20) <<< 15;
    endcase
  endfunction

  task automatic random_phase(input int sites);
    int          sent;
    int unsigned r;
    logic [31:0] step;
    logic [95:0] noise;
    in_word_t    w;
    sent = 0;
    cursor = $urandom;
    dense = 1'($urandom_range(1));
    while (sent < sites) begin
      r = $urandom_range(99);
      if (r < 4) begin
        // no site: kind, position and score must be ignored
        noise = {$urandom, $urandom, $urandom};
        w = noise[$bits(in_word_t)-1:0];
        w.has_site = 1'b0;
        w.end_of_sequence = ($urandom_range(3) == 0);
        send_word(w);
      end else begin
        if (r < 7) step = $urandom;
        else if (dense) step = $urandom_range(1, 6);
        else step = $urandom_range(1, 400);
        cursor = cursor + step;
        w = '{1'b1, 1'($urandom_range(1)), cursor, pick_score(),
              (dense ? $urandom_range(99) < 1 : $urandom_range(99) < 6)};
        send_word(w);
        sent++;
        if (w.end_of_sequence) begin
          cursor = $urandom;
          dense = 1'($urandom_range(1));
        end
      end
    end
    send_word('{1'b0, 1'b0, '0, '0, 1'b1});
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: flush on empty, lone sites, extreme fields, wrapped positions, ties
    send_word('{1'b0, 1'b0, '0, '0, 1'b1});
    send_site(1'b0, 32'd0, 32'h8000_0000, 1'b1);
    send_site(1'b1, 32'hffff_ffff, 32'h7fff_ffff, 1'b1);
    send_site(1'b0, 32'd10, 32'd928139, 1'b0);
    send_site(1'b0, 32'd20, 32'd928138, 1'b0);
    send_site(1'b1, 32'd25, 32'd866424, 1'b0);
    send_site(1'b1, 32'd30, 32'd866424, 1'b0);
    send_site(1'b0, 32'd110, 32'd500, 1'b0);
    send_site(1'b0, 32'd111, 32'd900, 1'b0);
    send_site(1'b1, 32'd400, 32'hffff_0000, 1'b0);
    send_word('{1'b0, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 1'b0});
    send_site(1'b0, 32'hffff_fff0, 32'd1, 1'b0);
    send_site(1'b0, 32'd5, 32'd2, 1'b0);
    send_site(1'b0, 32'd3, 32'd7, 1'b0);
    send_site(1'b1, 32'd6, 32'h7fff_ffff, 1'b0);
    send_site(1'b1, 32'd8, 32'h7fff_ffff, 1'b1);
    send_word('{1'b0, 1'b0, '0, '0, 1'b0});
    // fill the buffer to force early retirement
    for (int i = 0; i < 70; i++) send_site(1'b0, 32'(i), 32'(i), 1'b0);
    send_word('{1'b0, 1'b0, '0, '0, 1'b1});

    no_idle = 1'b1;
    random_phase(25);
    no_idle = 1'b0;
    random_phase(20);
    load_config(10'd0, 10'd0, 32'h8000_0000, 32'h8000_0000);
    random_phase(25);
    load_config(10'd1023, 10'd1023, 32'h7fff_ffff, 32'h7fff_ffff);
    random_phase(25);
    settle();
    random_phase(20);
    load_config(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), 32'd0,
                32'h0001_0000);
    random_phase(25);
    load_config(10'd300, 10'd5, $urandom, $urandom);
    random_phase(25);

    settle();
    if (fails == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
